// File: rtl/core/bale_pkg.sv
// Shared types, sizes and command codes for the bounded array list engine.
package bale_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 5;
  localparam int POS_W      = 4;
  localparam int VAL_W      = 32;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_SEARCH     = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic                    accepted;
    logic signed [VAL_W-1:0] read_data;
    logic                    found;
    logic [CNT_W-1:0]        count;
    logic                    is_empty;
    logic                    is_full;
  } rsp_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    cnt_t lo;
    cnt_t count;
  } cell_ctl_t;

endpackage

// File: rtl/core/bale_cell.sv
// One slot of the list: holds a word, shifts with its neighbors, compares.
module bale_cell (
  input  logic               clk,
  input  bale_pkg::cnt_t     idx,
  input  bale_pkg::cell_ctl_t ctl,
  input  bale_pkg::word_t    left,
  input  bale_pkg::word_t    right,
  input  bale_pkg::word_t    key,
  output bale_pkg::word_t    data,
  output logic               hit,
  output bale_pkg::word_t    tail_data
);
  import bale_pkg::*;

  logic             load;
  logic             take_left;
  logic             take_right;
  logic [CNT_W:0]   idx_inc;
  word_t            data_next;

  assign idx_inc    = {1'b0, idx} + (CNT_W + 1)'(1);
  assign load       = ctl.shift_up && (idx == ctl.lo);
  assign take_left  = ctl.shift_up && (idx > ctl.lo) && (idx <= ctl.count);
  assign take_right = ctl.shift_down && (idx_inc < {1'b0, ctl.count});

  always_comb begin
    data_next = data;
    if (load) begin
      data_next = key;
    end else if (take_left) begin
      data_next = left;
    end else if (take_right) begin
      data_next = right;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign hit       = (idx < ctl.count) && (data == key);
  assign tail_data = data & {DATA_WIDTH{idx_inc == {1'b0, ctl.count}}};

endmodule

// File: rtl/core/bounded_array_list_engine.sv
// Top level of the bounded array list engine: command decode, count, cell row, result register.
//
// One command is taken per clock cycle and its result appears in the output register on the
// next cycle. Each slot of the list is a cell that shifts to or from its neighbor or compares
// against the search key in the same cycle as all other cells, so insert, push, pop and search
// all act as they are taken; the rate is bounded only by the result register being taken.
// Capacity is written on cfg_we and clamps to 1..16; after reset the list is empty.
module bounded_array_list_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  bale_pkg::cmd_t       cmd_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output bale_pkg::rsp_t       rsp_data,
  input  logic                 cfg_we,
  input  logic [bale_pkg::CAP_W-1:0] cfg_wdata
);
  import bale_pkg::*;

  logic [CAP_W-1:0] capacity;
  cnt_t             count;
  cnt_t             count_next;
  cnt_t             cap_eff;
  logic             cmd_fire;
  logic             full;
  logic             ok;
  logic             any_hit;
  word_t            tail_or;
  word_t            key;
  cell_ctl_t        ctl;
  rsp_t             rsp_next;

  word_t            cell_data [DEPTH];
  word_t            cell_tail [DEPTH];
  logic [DEPTH-1:0] cell_hit;

  assign cmd_stall = rsp_valid && rsp_stall;
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign key       = cmd_data.item_value[DATA_WIDTH-1:0];

  always_comb begin
    if (capacity == '0) begin
      cap_eff = cnt_t'(1);
    end else if (CNT_W'(capacity) > cnt_t'(DEPTH)) begin
      cap_eff = cnt_t'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign full = (count >= cap_eff);

  always_comb begin
    any_hit = 1'b0;
    tail_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_hit = any_hit | cell_hit[i];
      tail_or = tail_or | cell_tail[i];
    end
  end

  always_comb begin
    ok             = 1'b0;
    ctl.shift_up   = 1'b0;
    ctl.shift_down = 1'b0;
    ctl.lo         = count;
    ctl.count      = count;
    count_next     = count;
    rsp_next       = '0;
    unique case (cmd_data.cmd)
      OP_INSERT: begin
        ok     = (CNT_W'(cmd_data.position) < count) && !full;
        ctl.lo = CNT_W'(cmd_data.position);
        ctl.shift_up = ok;
      end
      OP_PUSH_FRONT: begin
        ok     = !full;
        ctl.lo = '0;
        ctl.shift_up = ok;
      end
      OP_PUSH_BACK: begin
        ok     = !full;
        ctl.lo = count;
        ctl.shift_up = ok;
      end
      OP_POP_BACK: begin
        ok = (count != '0);
        rsp_next.read_data = ok ? VAL_W'(tail_or) : '0;
      end
      OP_POP_FRONT: begin
        ok = (count != '0);
        ctl.shift_down = ok;
      end
      OP_SEARCH: begin
        ok = 1'b1;
        rsp_next.found = any_hit;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (ok && ctl.shift_up) begin
      count_next = count + cnt_t'(1);
    end else if (ok && (cmd_data.cmd == OP_POP_BACK || cmd_data.cmd == OP_POP_FRONT)) begin
      count_next = count - cnt_t'(1);
    end
    ctl.shift_up   = ctl.shift_up && cmd_fire;
    ctl.shift_down = ctl.shift_down && cmd_fire;
    rsp_next.accepted = ok;
    rsp_next.count    = count_next;
    rsp_next.is_empty = (count_next == '0);
    rsp_next.is_full  = (count_next >= cap_eff);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_in;
    word_t right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end
    bale_cell u_cell (
      .clk       (clk),
      .idx       (cnt_t'(g)),
      .ctl       (ctl),
      .left      (left_in),
      .right     (right_in),
      .key       (key),
      .data      (cell_data[g]),
      .hit       (cell_hit[g]),
      .tail_data (cell_tail[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_W'(16);
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd_fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      rsp_data <= rsp_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(DEPTH))
    else $error("list count above depth");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> rsp_valid && (rsp_data.count == count))
    else $error("result count differs from list count");

  a_search_keeps: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && (cmd_data.cmd == OP_SEARCH) |=> count == $past(count))
    else $error("search changed the count");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && (cmd_data.cmd == OP_POP_BACK) && (count == '0)
      |=> !rsp_data.accepted && (rsp_data.read_data == '0))
    else $error("pop on empty list took effect");
`endif

endmodule
